@@ rtl/core/ovr_pkg.sv @@
// ---------------------------------------------------------------------------
// ovr_pkg
// Shared widths, action codes and score limits of the one-vs-rest classifier.
// ---------------------------------------------------------------------------
package ovr_pkg;

   // field widths of the request and response beats
   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 4;
   localparam int FEAT_W   = 12;
   localparam int VALUE_W  = 16;
   localparam int LABEL_W  = 16;
   localparam int SCORE_W  = 31;
   localparam int CFG_W    = 5;

   // accumulator and biased score widths
   localparam int ACC_W = 48;
   localparam int SUM_W = 49;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BIAS   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

   // score limits, plus and minus 35.0 in q8.24
   localparam logic signed [SUM_W-1:0] CLIP_HI = 49'sd587202560;
   localparam logic signed [SUM_W-1:0] CLIP_LO = -49'sd587202560;

   // most classes that may vote
   localparam int CLASS_LIMIT = 16;

endpackage

@@ rtl/core/ovr_req_if.sv @@
// ---------------------------------------------------------------------------
// ovr_req_if
// Request channel: load beats for weights, biases and labels, feature beats.
// ---------------------------------------------------------------------------
interface ovr_req_if;
   logic                                valid;
   logic                                ready;
   logic [ovr_pkg::ACTION_W-1:0]        action;
   logic [ovr_pkg::SLOT_W-1:0]          class_slot;
   logic [ovr_pkg::FEAT_W-1:0]          feature_index;
   logic signed [ovr_pkg::VALUE_W-1:0]  sample_value;
   logic signed [ovr_pkg::LABEL_W-1:0]  class_label;
   logic                                last_feature;

   modport source (
      output valid, action, class_slot, feature_index, sample_value,
             class_label, last_feature,
      input  ready
   );
   modport sink (
      input  valid, action, class_slot, feature_index, sample_value,
             class_label, last_feature,
      output ready
   );
endinterface

@@ rtl/core/ovr_rsp_if.sv @@
// ---------------------------------------------------------------------------
// ovr_rsp_if
// Response channel: one decision beat per image.
// ---------------------------------------------------------------------------
interface ovr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ovr_pkg::LABEL_W-1:0]  predicted_label;
   logic [ovr_pkg::SLOT_W-1:0]          predicted_slot;
   logic signed [ovr_pkg::SCORE_W-1:0]  winning_score;

   modport source (
      output valid, predicted_label, predicted_slot, winning_score,
      input  ready
   );
   modport sink (
      input  valid, predicted_label, predicted_slot, winning_score,
      output ready
   );
endinterface

@@ rtl/core/ovr_ram.sv @@
// ---------------------------------------------------------------------------
// ovr_ram
// Generic simple dual-port ram, one write and one registered read port.
// ---------------------------------------------------------------------------
module ovr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/one_vs_rest_logistic_classifier.sv @@
// ---------------------------------------------------------------------------
// one_vs_rest_logistic_classifier
// Fixed-point one-vs-rest logistic regression inference engine.
// ---------------------------------------------------------------------------
// Load beats write one q4.12 weight (class, feature) or one class bias and
// label. A feature beat multiplies its q4.12 value with that feature's
// weight of each voting class and adds the q8.24 product to the class's
// 48-bit accumulator. The classes are walked one per cycle through a
// five-stage read-multiply-add-write pipeline around the weight and
// accumulator rams, and no new beat is taken until the pipeline has
// drained. A beat marked last also adds each bias, clips each score to
// +/-35.0 and keeps the lowest class with the largest score in the same
// pass; the LABEL state fetches the winner's label and the EMIT state
// loads the response register, which frees the request side: new beats
// are taken while a decision waits, and only the next decision waits for
// it to drain. Accumulators read as zero after reset and after each
// decision through a valid bit per class, so no clearing pass is
// needed. Weights, biases and labels hold nothing defined until written.
// ---------------------------------------------------------------------------
module one_vs_rest_logistic_classifier #(
   parameter int MAX_CLASSES  = 16,
   parameter int MAX_FEATURES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration: number of voting classes
   input  logic                       csr_we,
   input  logic [ovr_pkg::CFG_W-1:0]  csr_wdata,
   // channels
   ovr_req_if.sink                    req_bus,
   ovr_rsp_if.source                  rsp_bus
);

   localparam int CW = $clog2(MAX_CLASSES);
   localparam int WDEPTH = MAX_CLASSES * MAX_FEATURES;
   localparam int WA = $clog2(WDEPTH);
   localparam int BLW = ovr_pkg::VALUE_W + ovr_pkg::LABEL_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_LABEL = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;

   // configuration register
   logic [ovr_pkg::CFG_W-1:0] classes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         classes_ff <= ovr_pkg::CFG_W'(1);
      end else if (csr_we) begin
         classes_ff <= csr_wdata;
      end
   end

   // number of voting classes: zero counts as one, limited to the class limit
   // and to the store size
   logic [6:0]    active_n;
   logic [CW-1:0] last_cls;

   always_comb begin
      active_n = 7'(classes_ff);
      if (active_n == 7'd0) begin
         active_n = 7'd1;
      end
      if (int'(active_n) > ovr_pkg::CLASS_LIMIT) begin
         active_n = 7'(ovr_pkg::CLASS_LIMIT);
      end
      if (int'(active_n) > MAX_CLASSES) begin
         active_n = 7'(MAX_CLASSES);
      end
   end

   assign last_cls = CW'(active_n - 7'd1);

   // request decode
   logic req_fire;
   logic slot_ok;
   logic feat_ok;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign slot_ok  = int'(req_bus.class_slot) < MAX_CLASSES;
   assign feat_ok  = int'(req_bus.feature_index) < MAX_FEATURES;

   // latched feature beat
   logic [ovr_pkg::FEAT_W-1:0]         feat_ff;
   logic signed [ovr_pkg::VALUE_W-1:0] value_ff;
   logic                               feat_ok_ff;
   logic                               last_ff;

   // class walk: class counter and weight row base
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [WA-1:0] base_ff, base_in;

   // pipeline valid and class tags
   logic          s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [CW-1:0] s1_cls_ff, s2_cls_ff, s3_cls_ff, s4_cls_ff;
   logic          s1_accv_ff;

   // pipeline data
   logic signed [31:0]                 s2_prod_ff;
   logic [ovr_pkg::ACC_W-1:0]          s2_acc_ff;
   logic signed [ovr_pkg::VALUE_W-1:0] s2_bias_ff;
   logic signed [ovr_pkg::ACC_W-1:0]   s3_sum_ff;
   logic signed [ovr_pkg::VALUE_W-1:0] s3_bias_ff;
   logic signed [ovr_pkg::SCORE_W-1:0] s4_score_ff;

   // running winner
   logic [CW-1:0]                      best_ff;
   logic signed [ovr_pkg::SCORE_W-1:0] best_score_ff;

   // accumulator valid bits, a cleared entry reads as zero
   logic [MAX_CLASSES-1:0] acc_vld_ff;

   // response register
   logic                               rsp_valid_ff;
   logic signed [ovr_pkg::LABEL_W-1:0] rsp_label_ff;
   logic [ovr_pkg::SLOT_W-1:0]         rsp_slot_ff;
   logic signed [ovr_pkg::SCORE_W-1:0] rsp_score_ff;
   logic                               emit_go;

   // ram ports
   logic                      w_we;
   logic [WA-1:0]             w_waddr;
   logic [WA-1:0]             w_raddr;
   logic [ovr_pkg::VALUE_W-1:0] w_rdata;

   logic                      bl_we;
   logic [CW-1:0]             bl_raddr;
   logic [BLW-1:0]            bl_rdata;

   logic [ovr_pkg::ACC_W-1:0] acc_rdata;
   logic [ovr_pkg::ACC_W-1:0] acc_sum;

   // weight store, row per class, column per feature
   assign w_we = req_fire && (req_bus.action == ovr_pkg::ACT_WEIGHT) && slot_ok && feat_ok;
   assign w_waddr = WA'(int'(req_bus.class_slot) * MAX_FEATURES + int'(req_bus.feature_index));
   assign w_raddr = base_ff + WA'(feat_ff);

   ovr_ram #(
      .WIDTH (ovr_pkg::VALUE_W),
      .DEPTH (WDEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (req_bus.sample_value),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   // bias in the low half, label in the high half; the label of the winner
   // is read once the walk is over
   assign bl_we = req_fire && (req_bus.action == ovr_pkg::ACT_BIAS) && slot_ok;
   assign bl_raddr = ((state_ff == ST_LABEL) || (state_ff == ST_EMIT)) ? best_ff : cnt_ff;

   ovr_ram #(
      .WIDTH (BLW),
      .DEPTH (MAX_CLASSES)
   ) u_bias_label_ram (
      .clock   (clock),
      .wr_en   (bl_we),
      .wr_addr (CW'(req_bus.class_slot)),
      .wr_data ({req_bus.class_label, req_bus.sample_value}),
      .rd_addr (bl_raddr),
      .rd_data (bl_rdata)
   );

   // accumulators: read at issue, written back from stage s2; classes
   // in flight are always distinct, so no forwarding is needed
   assign acc_sum = s2_acc_ff + ovr_pkg::ACC_W'(s2_prod_ff);

   ovr_ram #(
      .WIDTH (ovr_pkg::ACC_W),
      .DEPTH (MAX_CLASSES)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (s2_vld_ff),
      .wr_addr (s2_cls_ff),
      .wr_data (acc_sum),
      .rd_addr (cnt_ff),
      .rd_data (acc_rdata)
   );

   // sequencer
   logic pipe_busy;

   assign pipe_busy = s1_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff;
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      base_in  = base_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in  = '0;
            base_in = '0;
            if (req_fire && (req_bus.action == ovr_pkg::ACT_SAMPLE)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in  = cnt_ff + CW'(1);
            base_in = base_ff + WA'(MAX_FEATURES);
            if (cnt_ff == last_cls) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = last_ff ? ST_LABEL : ST_IDLE;
            end
         end
         ST_LABEL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      base_ff <= base_in;
   end

   // latch the feature beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         feat_ff    <= req_bus.feature_index;
         value_ff   <= req_bus.sample_value;
         feat_ok_ff <= feat_ok;
         last_ff    <= req_bus.last_feature;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= (state_ff == ST_RUN);
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // stage data: product, write-back sum, biased and clipped score
   logic signed [31:0]                s1_prod;
   logic signed [ovr_pkg::SUM_W-1:0]  s3_total;
   logic signed [ovr_pkg::SUM_W-1:0]  s3_clip;

   assign s1_prod  = signed'(w_rdata) * value_ff;
   assign s3_total = ovr_pkg::SUM_W'(s3_sum_ff) + (ovr_pkg::SUM_W'(s3_bias_ff) <<< 12);

   always_comb begin
      s3_clip = s3_total;
      if (s3_total > ovr_pkg::CLIP_HI) begin
         s3_clip = ovr_pkg::CLIP_HI;
      end else if (s3_total < ovr_pkg::CLIP_LO) begin
         s3_clip = ovr_pkg::CLIP_LO;
      end
   end

   always_ff @(posedge clock) begin
      s1_cls_ff  <= cnt_ff;
      s1_accv_ff <= acc_vld_ff[cnt_ff];
      // feature past the store adds nothing
      s2_prod_ff <= feat_ok_ff ? s1_prod : 32'sd0;
      s2_acc_ff  <= s1_accv_ff ? acc_rdata : '0;
      s2_bias_ff <= signed'(bl_rdata[ovr_pkg::VALUE_W-1:0]);
      s2_cls_ff  <= s1_cls_ff;
      s3_sum_ff  <= signed'(acc_sum);
      s3_bias_ff <= s2_bias_ff;
      s3_cls_ff  <= s2_cls_ff;
      s4_score_ff <= ovr_pkg::SCORE_W'(s3_clip);
      s4_cls_ff  <= s3_cls_ff;
      // lowest class wins ties
      if (s4_vld_ff && last_ff &&
          ((s4_cls_ff == '0) || (s4_score_ff > best_score_ff))) begin
         best_ff       <= s4_cls_ff;
         best_score_ff <= s4_score_ff;
      end
   end

   // accumulator valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else if (emit_go) begin
         acc_vld_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_vld_ff[s2_cls_ff] <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_label_ff <= signed'(bl_rdata[BLW-1:ovr_pkg::VALUE_W]);
         rsp_slot_ff  <= ovr_pkg::SLOT_W'(best_ff);
         rsp_score_ff <= best_score_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.predicted_label = rsp_label_ff;
   assign rsp_bus.predicted_slot  = rsp_slot_ff;
   assign rsp_bus.winning_score   = rsp_score_ff;

endmodule
